FILE: rtl/assert_macros.svh
// Assertion macros used by the top level of the design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/teo_pkg.sv
package teo_pkg;

   localparam int PULSE_BITS   = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_ITERS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
   localparam int ITER_BITS    = 5;

   // Configuration register indexes.
   localparam logic [1:0] REG_FWD_CM    = 2'd0;
   localparam logic [1:0] REG_STR_CM    = 2'd1;
   localparam logic [1:0] REG_HEAD_GAIN = 2'd2;
   localparam logic [1:0] REG_CORR_GAIN = 2'd3;

   localparam logic [23:0] FWD_CM_RESET    = 24'd148394;
   localparam logic [23:0] STR_CM_RESET    = 24'd148394;
   localparam logic [31:0] HEAD_GAIN_RESET = 32'd6615859;
   localparam logic [15:0] CORR_GAIN_RESET = 16'd6850;

   localparam logic signed [33:0] TRIG_ONE  = 34'sd1073741824;
   localparam logic signed [33:0] CORDIC_KX = 34'sd652032874;
   localparam logic signed [33:0] TRIG_ZERO = 34'sd0;

   typedef struct packed {
      logic                         command;
      logic signed [PULSE_BITS-1:0] left_pulses;
      logic signed [PULSE_BITS-1:0] right_pulses;
      logic signed [PULSE_BITS-1:0] aux_pulses;
      logic signed [31:0]           load_x;
      logic signed [31:0]           load_y;
      logic [15:0]                  load_heading;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [15:0]        heading;
      logic               saturated;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_SCALE, ST_DIFF, ST_HEAD, ST_CORR, ST_TRAVEL,
      ST_CORDIC, ST_QUAD, ST_PROD_A, ST_PROD_B, ST_POS, ST_DONE
   } state_type;

   // Datapath step commands, issued by the controller states.
   typedef struct packed {
      logic capture;
      logic load;
      logic scale;
      logic diff;
      logic head;
      logic corr;
      logic travel;
      logic cordic_init;
      logic cordic_step;
      logic quad;
      logic prod_a;
      logic prod_b;
      logic pos;
   } cmd_type;

   typedef struct packed {
      logic is_load;
      logic cordic_last;
   } status_type;

   // Arctangent table in units of 2^-32 turn.
   function automatic logic [29:0] atan_turns(input logic [ITER_BITS-1:0] i);
      logic [29:0] v;
      unique case (i)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10680862;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/teo_ctrl.sv
module teo_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  teo_pkg::status_type status,
   output teo_pkg::cmd_type    cmd
);

   teo_pkg::state_type state_ff, state_in;
   logic               busy;

   // The result is held until taken; a new request is accepted only when idle or as the result is taken.
   assign busy      = (state_ff != teo_pkg::ST_IDLE) && (state_ff != teo_pkg::ST_DONE);
   assign req_ready = !busy && !(state_ff == teo_pkg::ST_DONE && !rsp_ready);
   assign rsp_valid = (state_ff == teo_pkg::ST_DONE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         teo_pkg::ST_IDLE, teo_pkg::ST_DONE: begin
            if (req_valid && req_ready) begin
               state_in = teo_pkg::ST_LOAD;
            end else if (state_ff == teo_pkg::ST_DONE && rsp_ready) begin
               state_in = teo_pkg::ST_IDLE;
            end
         end
         teo_pkg::ST_LOAD: begin
            state_in = status.is_load ? teo_pkg::ST_DONE : teo_pkg::ST_SCALE;
         end
         teo_pkg::ST_SCALE:  state_in = teo_pkg::ST_DIFF;
         teo_pkg::ST_DIFF:   state_in = teo_pkg::ST_HEAD;
         teo_pkg::ST_HEAD:   state_in = teo_pkg::ST_CORR;
         teo_pkg::ST_CORR:   state_in = teo_pkg::ST_TRAVEL;
         teo_pkg::ST_TRAVEL: state_in = teo_pkg::ST_CORDIC;
         teo_pkg::ST_CORDIC: begin
            if (status.cordic_last) begin
               state_in = teo_pkg::ST_QUAD;
            end
         end
         teo_pkg::ST_QUAD:   state_in = teo_pkg::ST_PROD_A;
         teo_pkg::ST_PROD_A: state_in = teo_pkg::ST_PROD_B;
         teo_pkg::ST_PROD_B: state_in = teo_pkg::ST_POS;
         teo_pkg::ST_POS:    state_in = teo_pkg::ST_DONE;
         default:            state_in = teo_pkg::ST_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd             = '0;
      cmd.capture     = req_valid && req_ready;
      cmd.load        = (state_ff == teo_pkg::ST_LOAD) && status.is_load;
      cmd.scale       = (state_ff == teo_pkg::ST_SCALE);
      cmd.diff        = (state_ff == teo_pkg::ST_DIFF);
      cmd.head        = (state_ff == teo_pkg::ST_HEAD);
      cmd.corr        = (state_ff == teo_pkg::ST_CORR);
      cmd.travel      = (state_ff == teo_pkg::ST_TRAVEL);
      cmd.cordic_init = (state_ff == teo_pkg::ST_TRAVEL);
      cmd.cordic_step = (state_ff == teo_pkg::ST_CORDIC);
      cmd.quad        = (state_ff == teo_pkg::ST_QUAD);
      cmd.prod_a      = (state_ff == teo_pkg::ST_PROD_A);
      cmd.prod_b      = (state_ff == teo_pkg::ST_PROD_B);
      cmd.pos         = (state_ff == teo_pkg::ST_POS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= teo_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/teo_datapath.sv
module teo_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data,
   input  teo_pkg::req_type    req_data,
   input  teo_pkg::cmd_type    cmd,
   output teo_pkg::status_type status,
   output teo_pkg::rsp_type    rsp_data
);

   localparam int PB = teo_pkg::PULSE_BITS;

   // Configuration registers.
   logic [23:0] fwd_cm_ff, str_cm_ff;
   logic [31:0] head_gain_ff;
   logic [15:0] corr_gain_ff;

   // Pose state.
   logic signed [31:0] x_ff, y_ff;
   logic [15:0]        head_ff;
   logic               sat_ff;

   // Work registers.
   teo_pkg::req_type   req_ff;
   logic signed [PB+24:0] l_ff, r_ff, a_ff;
   logic signed [PB+25:0] d_ff;
   logic signed [PB+25:0] sum_ff;
   logic signed [33:0] fwd_ff, str_ff;
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic [teo_pkg::ITER_BITS-1:0] iter_ff;
   logic signed [33:0] sin_ff, cos_ff;
   logic signed [67:0] px_ff, py_ff;
   logic [PB+41:0]     corr_prod_ff;

   // Scaled travel, rounded from Q.24 to Q16.16.
   logic signed [PB+25:0] l_scaled, r_scaled, a_scaled;
   assign l_scaled = (req_ff.left_pulses * $signed({1'b0, fwd_cm_ff}) + 128) >>> 8;
   assign r_scaled = (req_ff.right_pulses * $signed({1'b0, fwd_cm_ff}) + 128) >>> 8;
   assign a_scaled = (req_ff.aux_pulses * $signed({1'b0, str_cm_ff}) + 128) >>> 8;

   // Heading increment: d times gain, rounded to 16 bits.
   logic [63:0] head_prod;
   logic [15:0] head_inc;
   assign head_prod = 64'(d_ff) * {32'd0, head_gain_ff} + 64'h8000_0000;
   assign head_inc  = head_prod[47:32];

   // Strafe correction from the magnitude of d.
   logic [PB+25:0] d_mag;
   logic [PB+25:0] corr_mag;
   logic signed [PB+27:0] corr_signed;
   assign d_mag       = d_ff[PB+25] ? (PB+26)'(-d_ff) : d_ff;
   assign corr_mag    = (PB+26)'((corr_prod_ff + 32768) >> 16);
   assign corr_signed = d_ff[PB+25] ? -$signed({2'b00, corr_mag})
                                    : $signed({2'b00, corr_mag});

   // Travel clamp to plus or minus 2^32-1.
   localparam logic signed [PB+27:0] TMAX = (PB+28)'(64'd4294967295);
   logic signed [PB+27:0] fwd_raw, str_raw;
   logic fwd_hi, fwd_lo, str_hi, str_lo;
   assign fwd_raw = (PB+28)'(sum_ff >>> 1);
   assign str_raw = (PB+28)'(a_ff) - corr_signed;
   assign fwd_hi  = fwd_raw > TMAX;
   assign fwd_lo  = fwd_raw < -TMAX;
   assign str_hi  = str_raw > TMAX;
   assign str_lo  = str_raw < -TMAX;

   // CORDIC iteration.
   logic signed [33:0] xs, ys;
   logic [29:0]        atn;
   assign xs  = cx_ff >>> iter_ff;
   assign ys  = cy_ff >>> iter_ff;
   assign atn = teo_pkg::atan_turns(iter_ff);

   // Clamped CORDIC outputs and quadrant fix.
   logic signed [33:0] xc, yc;
   logic [1:0]         quad;
   assign xc   = (cx_ff > teo_pkg::TRIG_ONE) ? teo_pkg::TRIG_ONE :
                 (cx_ff < -teo_pkg::TRIG_ONE) ? -teo_pkg::TRIG_ONE : cx_ff;
   assign yc   = (cy_ff > teo_pkg::TRIG_ONE) ? teo_pkg::TRIG_ONE :
                 (cy_ff < -teo_pkg::TRIG_ONE) ? -teo_pkg::TRIG_ONE : cy_ff;
   assign quad = head_ff[15:14];

   // Position update with saturation.
   logic signed [67:0] dx_full, dy_full;
   logic signed [37:0] dx, dy;
   logic signed [38:0] nx, ny;
   localparam logic signed [38:0] PMAX = 39'sd2147483647;
   localparam logic signed [38:0] PMIN = -39'sd2147483648;
   assign dx_full = (px_ff + (68'sd1 <<< 29)) >>> 30;
   assign dy_full = (py_ff + (68'sd1 <<< 29)) >>> 30;
   assign dx = 38'(dx_full);
   assign dy = 38'(dy_full);
   assign nx = 39'(x_ff) + 39'(dx);
   assign ny = 39'(y_ff) + 39'(dy);

   assign status.is_load     = req_ff.command;
   assign status.cordic_last = (iter_ff == teo_pkg::ITER_BITS'(teo_pkg::CORDIC_ITERS - 1));

   assign rsp_data.pos_x     = x_ff;
   assign rsp_data.pos_y     = y_ff;
   assign rsp_data.heading   = head_ff;
   assign rsp_data.saturated = sat_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_cm_ff    <= teo_pkg::FWD_CM_RESET;
         str_cm_ff    <= teo_pkg::STR_CM_RESET;
         head_gain_ff <= teo_pkg::HEAD_GAIN_RESET;
         corr_gain_ff <= teo_pkg::CORR_GAIN_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            teo_pkg::REG_FWD_CM:    fwd_cm_ff    <= csr_data[23:0];
            teo_pkg::REG_STR_CM:    str_cm_ff    <= csr_data[23:0];
            teo_pkg::REG_HEAD_GAIN: head_gain_ff <= csr_data;
            teo_pkg::REG_CORR_GAIN: corr_gain_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Pose registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= '0;
         y_ff    <= '0;
         head_ff <= '0;
         sat_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            x_ff    <= req_ff.load_x;
            y_ff    <= req_ff.load_y;
            head_ff <= req_ff.load_heading;
            sat_ff  <= 1'b0;
         end
         if (cmd.scale) begin
            sat_ff <= 1'b0;
         end
         if (cmd.head) begin
            head_ff <= head_ff + head_inc;
         end
         if (cmd.travel && (fwd_hi || fwd_lo || str_hi || str_lo)) begin
            sat_ff <= 1'b1;
         end
         if (cmd.pos) begin
            x_ff <= (nx > PMAX) ? 32'sh7FFF_FFFF : (nx < PMIN) ? 32'sh8000_0000 : 32'(nx);
            y_ff <= (ny > PMAX) ? 32'sh7FFF_FFFF : (ny < PMIN) ? 32'sh8000_0000 : 32'(ny);
            if (nx > PMAX || nx < PMIN || ny > PMAX || ny < PMIN) begin
               sat_ff <= 1'b1;
            end
         end
      end
   end

   // Working registers, one step per command.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.scale) begin
         l_ff <= (PB+25)'(l_scaled);
         r_ff <= (PB+25)'(r_scaled);
         a_ff <= (PB+25)'(a_scaled);
      end
      if (cmd.diff) begin
         d_ff   <= (PB+26)'(l_ff) - (PB+26)'(r_ff);
         sum_ff <= (PB+26)'(l_ff) + (PB+26)'(r_ff);
      end
      if (cmd.head) begin
         corr_prod_ff <= (PB+42)'(d_mag) * (PB+42)'(corr_gain_ff);
      end
      if (cmd.travel) begin
         fwd_ff <= fwd_hi ? 34'(TMAX) : fwd_lo ? -34'(TMAX) : 34'(fwd_raw);
         str_ff <= str_hi ? 34'(TMAX) : str_lo ? -34'(TMAX) : 34'(str_raw);
      end
      if (cmd.cordic_init) begin
         cx_ff   <= teo_pkg::CORDIC_KX;
         cy_ff   <= teo_pkg::TRIG_ZERO;
         cz_ff   <= 34'({head_ff[13:0], 16'd0});
         iter_ff <= '0;
      end
      if (cmd.cordic_step) begin
         if (!cz_ff[33]) begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - 34'(atn);
         end else begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + 34'(atn);
         end
         iter_ff <= iter_ff + 1'b1;
      end
      if (cmd.quad) begin
         case (quad)
            2'd0: begin sin_ff <= yc;  cos_ff <= xc;  end
            2'd1: begin sin_ff <= xc;  cos_ff <= -yc; end
            2'd2: begin sin_ff <= -yc; cos_ff <= -xc; end
            default: begin sin_ff <= -xc; cos_ff <= yc; end
         endcase
      end
      if (cmd.prod_a) begin
         px_ff <= 68'(fwd_ff) * 68'(sin_ff);
         py_ff <= 68'(fwd_ff) * 68'(cos_ff);
      end
      if (cmd.prod_b) begin
         px_ff <= px_ff + 68'(str_ff) * 68'(cos_ff);
         py_ff <= py_ff - 68'(str_ff) * 68'(sin_ff);
      end
   end

endmodule

FILE: rtl/three_encoder_odometry.sv
// An update request passes the scale, difference, heading, correction, travel, CORDIC (16 steps),
// quadrant, product and position states; a load goes straight to its result. One request at a time.
// The next request is taken as the previous result leaves.
// Reset (synchronous, active high) clears the pose and loads the default gains.
`include "assert_macros.svh"
module three_encoder_odometry (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  teo_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output teo_pkg::rsp_type  rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);

   teo_pkg::cmd_type    cmd;
   teo_pkg::status_type status;

   teo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   teo_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

   // A request taken never leads to a result at once.
   `ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && req_ready, !rsp_valid, "early rsp")
   // An unaccepted result stays visible.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
   // The position step never falls in the same cycle as a load or a CORDIC step.
   `ASSERT_IMPLY(a_one_cmd, clock, reset, cmd.pos, !cmd.load && !cmd.cordic_step, "cmd clash")

endmodule
